// File: sv/krt_pkg.sv
`default_nettype none
package krt_pkg;

   localparam int KRT_DEPTH = 32;
   localparam int KRT_ID_W  = 32;
   localparam int KRT_CAT_W = 2;
   localparam int KRT_REC_W = KRT_ID_W + KRT_CAT_W;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_LOOKUP = 3'd2,
      CMD_MODIFY = 3'd3,
      CMD_SORT   = 3'd4,
      CMD_CLEAR  = 3'd5,
      CMD_DUMP   = 3'd6
   } cmd_code_type;

   typedef enum logic [2:0] {
      RS_OK       = 3'd0,
      RS_DUP      = 3'd1,
      RS_NOTFOUND = 3'd2,
      RS_FULL     = 3'd3,
      RS_BADCAT   = 3'd4,
      RS_EMPTY    = 3'd5
   } rsp_status_type;

   typedef enum logic [1:0] {RD_J, RD_I, RD_I1} rd_sel_type;
   typedef enum logic [1:0] {WA_J, WA_I, WA_BEST} wa_sel_type;
   typedef enum logic [2:0] {WD_KEY, WD_NID, WD_RDATA, WD_BEST, WD_HOLD} wd_sel_type;
   typedef enum logic [1:0] {HS_RDATA, HS_KEY, HS_NID} hold_sel_type;
   typedef enum logic [1:0] {J_KEEP, J_CLR, J_INC, J_I1} j_op_type;
   typedef enum logic [1:0] {I_KEEP, I_CLR, I_INC, I_J} i_op_type;
   typedef enum logic [1:0] {C_KEEP, C_INC, C_DEC, C_CLR} cnt_op_type;

   // commands from controller to datapath
   typedef struct packed {
      logic           ld_req;
      rd_sel_type     rd_sel;
      logic           wr_en;
      wa_sel_type     wa_sel;
      wd_sel_type     wd_sel;
      logic           hold_ld;
      hold_sel_type   hold_sel;
      logic           best_ld_i;
      logic           best_ld_j;
      j_op_type       j_op;
      i_op_type       i_op;
      cnt_op_type     cnt_op;
      logic           out_ld;
      rsp_status_type out_status;
      logic           out_zero;
      logic           out_last;
   } ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic count_zero;
      logic full;
      logic j_end;
      logic j1_end;
      logic i_end;
      logic i1_end;
      logic match;
      logic better;
      logic best_is_i;
      logic cat_zero;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: sv/krt_ram.sv
`default_nettype none
module krt_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// File: sv/krt_ctrl.sv
`default_nettype none
module krt_ctrl
   import krt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_cmd,
   output logic            req_stall,
   input  wire sts_type    sts,
   output ctl_type         ctl
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_INS_WR, ST_MOD_WR, ST_DEL_RD, ST_DEL_WR,
      ST_SRT_OUT, ST_SRT_LD, ST_SRT_RD, ST_SRT_CHK, ST_SRT_SW1, ST_SRT_SW2,
      ST_DMP_RD, ST_DMP_LD, ST_DMP_NEXT, ST_EMIT
   } state_type;

   state_type      state_ff, state_in;
   cmd_code_type   cmd_ff, cmd_in;
   rsp_status_type st_ff, st_in;
   logic           zero_ff, zero_in;
   logic           last_ff, last_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      st_in    = st_ff;
      zero_in  = zero_ff;
      last_in  = last_ff;

      ctl.ld_req     = 1'b0;
      ctl.rd_sel     = RD_J;
      ctl.wr_en      = 1'b0;
      ctl.wa_sel     = WA_J;
      ctl.wd_sel     = WD_KEY;
      ctl.hold_ld    = 1'b0;
      ctl.hold_sel   = HS_RDATA;
      ctl.best_ld_i  = 1'b0;
      ctl.best_ld_j  = 1'b0;
      ctl.j_op       = J_KEEP;
      ctl.i_op       = I_KEEP;
      ctl.cnt_op     = C_KEEP;
      ctl.out_ld     = 1'b0;
      ctl.out_status = st_ff;
      ctl.out_zero   = zero_ff;
      ctl.out_last   = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.ld_req = 1'b1;
               ctl.j_op   = J_CLR;
               ctl.i_op   = I_CLR;
               cmd_in     = cmd_code_type'(req_cmd);
               last_in    = 1'b1;
               zero_in    = 1'b1;
               st_in      = RS_EMPTY;
               unique case (cmd_code_type'(req_cmd))
                  CMD_INSERT: state_in = ST_FIND_RD;
                  CMD_DELETE, CMD_LOOKUP, CMD_MODIFY:
                     state_in = sts.count_zero ? ST_EMIT : ST_FIND_RD;
                  CMD_SORT:   state_in = sts.count_zero ? ST_EMIT : ST_SRT_OUT;
                  CMD_CLEAR: begin
                     ctl.cnt_op = C_CLR;
                     st_in      = RS_OK;
                     state_in   = ST_EMIT;
                  end
                  CMD_DUMP:   state_in = sts.count_zero ? ST_EMIT : ST_DMP_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         // linear search for the key
         ST_FIND_RD: begin
            ctl.rd_sel = RD_J;
            if (sts.j_end) begin
               zero_in  = 1'b1;
               state_in = ST_EMIT;
               if (cmd_ff == CMD_INSERT) begin
                  if (sts.cat_zero) begin
                     st_in = RS_BADCAT;
                  end else if (sts.full) begin
                     st_in = RS_FULL;
                  end else begin
                     state_in = ST_INS_WR;
                  end
               end else begin
                  st_in = RS_NOTFOUND;
               end
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_FIND_CHK: begin
            if (sts.match) begin
               ctl.hold_ld  = 1'b1;
               ctl.hold_sel = HS_RDATA;
               zero_in      = 1'b0;
               st_in        = RS_OK;
               state_in     = ST_EMIT;
               unique case (cmd_ff)
                  CMD_INSERT: st_in = RS_DUP;
                  CMD_DELETE: begin
                     ctl.i_op = I_J;
                     state_in = ST_DEL_RD;
                  end
                  CMD_MODIFY: begin
                     if (sts.cat_zero) begin
                        st_in = RS_BADCAT;
                     end else begin
                        state_in = ST_MOD_WR;
                     end
                  end
                  default: st_in = RS_OK;
               endcase
            end else begin
               ctl.j_op = J_INC;
               state_in = ST_FIND_RD;
            end
         end
         // append at the end of the table
         ST_INS_WR: begin
            ctl.wr_en    = 1'b1;
            ctl.wa_sel   = WA_J;
            ctl.wd_sel   = WD_KEY;
            ctl.hold_ld  = 1'b1;
            ctl.hold_sel = HS_KEY;
            ctl.cnt_op   = C_INC;
            st_in        = RS_OK;
            zero_in      = 1'b0;
            state_in     = ST_EMIT;
         end
         ST_MOD_WR: begin
            ctl.wr_en    = 1'b1;
            ctl.wa_sel   = WA_J;
            ctl.wd_sel   = WD_NID;
            ctl.hold_ld  = 1'b1;
            ctl.hold_sel = HS_NID;
            state_in     = ST_EMIT;
         end
         // shift later entries down by one
         ST_DEL_RD: begin
            ctl.rd_sel = RD_I1;
            if (sts.i1_end) begin
               ctl.cnt_op = C_DEC;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            ctl.wr_en  = 1'b1;
            ctl.wa_sel = WA_I;
            ctl.wd_sel = WD_RDATA;
            ctl.i_op   = I_INC;
            state_in   = ST_DEL_RD;
         end
         // selection sort, outer pass
         ST_SRT_OUT: begin
            ctl.rd_sel = RD_I;
            if (sts.i_end) begin
               st_in    = RS_OK;
               zero_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SRT_LD;
            end
         end
         ST_SRT_LD: begin
            ctl.hold_ld   = 1'b1;
            ctl.hold_sel  = HS_RDATA;
            ctl.best_ld_i = 1'b1;
            ctl.j_op      = J_I1;
            state_in      = ST_SRT_RD;
         end
         ST_SRT_RD: begin
            ctl.rd_sel = RD_J;
            state_in   = sts.j_end ? ST_SRT_SW1 : ST_SRT_CHK;
         end
         ST_SRT_CHK: begin
            ctl.best_ld_j = sts.better;
            ctl.j_op      = J_INC;
            state_in      = ST_SRT_RD;
         end
         ST_SRT_SW1: begin
            if (sts.best_is_i) begin
               ctl.i_op = I_INC;
               state_in = ST_SRT_OUT;
            end else begin
               ctl.wr_en  = 1'b1;
               ctl.wa_sel = WA_I;
               ctl.wd_sel = WD_BEST;
               state_in   = ST_SRT_SW2;
            end
         end
         ST_SRT_SW2: begin
            ctl.wr_en  = 1'b1;
            ctl.wa_sel = WA_BEST;
            ctl.wd_sel = WD_HOLD;
            ctl.i_op   = I_INC;
            state_in   = ST_SRT_OUT;
         end
         // dump walk
         ST_DMP_RD: begin
            ctl.rd_sel = RD_J;
            state_in   = ST_DMP_LD;
         end
         ST_DMP_LD: begin
            ctl.hold_ld  = 1'b1;
            ctl.hold_sel = HS_RDATA;
            st_in        = RS_OK;
            zero_in      = 1'b0;
            last_in      = sts.j1_end;
            state_in     = ST_EMIT;
         end
         ST_DMP_NEXT: begin
            ctl.j_op = J_INC;
            state_in = ST_DMP_RD;
         end
         // hand one beat to the output register
         ST_EMIT: begin
            if (sts.out_free) begin
               ctl.out_ld = 1'b1;
               state_in   = last_ff ? ST_IDLE : ST_DMP_NEXT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= CMD_INSERT;
         st_ff    <= RS_OK;
         zero_ff  <= 1'b1;
         last_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         st_ff    <= st_in;
         zero_ff  <= zero_in;
         last_ff  <= last_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/krt_datapath.sv
`default_nettype none
module krt_datapath
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = KRT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] req_key_id,
   input  wire logic [31:0] req_new_id,
   input  wire logic [1:0]  req_category,
   input  wire logic        req_descending,
   input  wire ctl_type     ctl,
   output sts_type          sts,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_position,
   output logic [31:0]      rsp_rec_id,
   output logic [1:0]       rsp_rec_category,
   output logic [5:0]       rsp_count,
   output logic             rsp_last
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   logic [31:0]          key_ff, nid_ff;
   logic [1:0]           cat_ff;
   logic                 desc_ff;
   logic [CW-1:0]        count_ff, j_ff, i_ff;
   logic [IW-1:0]        best_ff;
   logic [KRT_REC_W-1:0] best_rec_ff, hold_ff, rdata, wdata, hold_in;
   logic [IW-1:0]        raddr, waddr;
   logic [CW:0]          i1, j1;
   logic                 rsp_valid_ff;
   logic [2:0]           out_status_ff;
   logic [4:0]           out_pos_ff;
   logic [KRT_REC_W-1:0] out_rec_ff;
   logic [5:0]           out_count_ff;
   logic                 out_last_ff;
   logic [IW+4:0]        pos_wide;
   logic [CW+5:0]        cnt_wide;
   logic                 out_free;

   assign i1 = {1'b0, i_ff} + 1'b1;
   assign j1 = {1'b0, j_ff} + 1'b1;

   // address and data selection
   always_comb begin
      unique case (ctl.rd_sel)
         RD_J:    raddr = j_ff[IW-1:0];
         RD_I:    raddr = i_ff[IW-1:0];
         RD_I1:   raddr = i1[IW-1:0];
         default: raddr = j_ff[IW-1:0];
      endcase
      unique case (ctl.wa_sel)
         WA_J:    waddr = j_ff[IW-1:0];
         WA_I:    waddr = i_ff[IW-1:0];
         WA_BEST: waddr = best_ff;
         default: waddr = j_ff[IW-1:0];
      endcase
      unique case (ctl.wd_sel)
         WD_KEY:   wdata = {key_ff, cat_ff};
         WD_NID:   wdata = {nid_ff, cat_ff};
         WD_RDATA: wdata = rdata;
         WD_BEST:  wdata = best_rec_ff;
         WD_HOLD:  wdata = hold_ff;
         default:  wdata = rdata;
      endcase
      unique case (ctl.hold_sel)
         HS_RDATA: hold_in = rdata;
         HS_KEY:   hold_in = {key_ff, cat_ff};
         HS_NID:   hold_in = {nid_ff, cat_ff};
         default:  hold_in = rdata;
      endcase
   end

   krt_ram #(
      .WIDTH(KRT_REC_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ctl.wr_en),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   // status back to the controller
   assign out_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == FULL_COUNT);
      sts.j_end      = (j_ff == count_ff);
      sts.j1_end     = (j1 >= {1'b0, count_ff});
      sts.i_end      = (i_ff == count_ff);
      sts.i1_end     = (i1 >= {1'b0, count_ff});
      sts.match      = (rdata[KRT_REC_W-1:KRT_CAT_W] == key_ff);
      sts.better     = desc_ff
         ? ($signed(best_rec_ff[KRT_REC_W-1:KRT_CAT_W]) < $signed(rdata[KRT_REC_W-1:KRT_CAT_W]))
         : ($signed(best_rec_ff[KRT_REC_W-1:KRT_CAT_W]) > $signed(rdata[KRT_REC_W-1:KRT_CAT_W]));
      sts.best_is_i  = (best_ff == i_ff[IW-1:0]);
      sts.cat_zero   = (cat_ff == '0);
      sts.out_free   = out_free;
   end

   // request fields and working registers
   always_ff @(posedge clock) begin
      if (ctl.ld_req) begin
         key_ff  <= req_key_id;
         nid_ff  <= req_new_id;
         cat_ff  <= req_category;
         desc_ff <= req_descending;
      end
      if (ctl.hold_ld) begin
         hold_ff <= hold_in;
      end
      if (ctl.best_ld_i) begin
         best_ff     <= i_ff[IW-1:0];
         best_rec_ff <= rdata;
      end else if (ctl.best_ld_j) begin
         best_ff     <= j_ff[IW-1:0];
         best_rec_ff <= rdata;
      end
      unique case (ctl.j_op)
         J_CLR:   j_ff <= '0;
         J_INC:   j_ff <= j1[CW-1:0];
         J_I1:    j_ff <= i1[CW-1:0];
         default: j_ff <= j_ff;
      endcase
      unique case (ctl.i_op)
         I_CLR:   i_ff <= '0;
         I_INC:   i_ff <= i1[CW-1:0];
         I_J:     i_ff <= j_ff;
         default: i_ff <= i_ff;
      endcase
   end

   // record count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         unique case (ctl.cnt_op)
            C_INC:   count_ff <= count_ff + 1'b1;
            C_DEC:   count_ff <= count_ff - 1'b1;
            C_CLR:   count_ff <= '0;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // output register
   assign pos_wide = {5'd0, j_ff[IW-1:0]};
   assign cnt_wide = {6'd0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_ld) begin
         out_status_ff <= ctl.out_status;
         out_pos_ff    <= ctl.out_zero ? 5'd0 : pos_wide[4:0];
         out_rec_ff    <= ctl.out_zero ? '0 : hold_ff;
         out_count_ff  <= cnt_wide[5:0];
         out_last_ff   <= ctl.out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_rec_id       = out_rec_ff[KRT_REC_W-1:KRT_CAT_W];
   assign rsp_rec_category = out_rec_ff[KRT_CAT_W-1:0];
   assign rsp_count        = out_count_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

// File: sv/keyed_record_table_with_sort.sv
// channel   direction  handshake           payload
// req       in         req_valid/req_stall cmd, key_id, new_id, category, descending
// rsp       out        rsp_valid/rsp_stall status, position, rec_id, rec_category, count, last
//
// each table entry visited takes a read state and then a check, write or load
// state on the record ram, which has one write port and a registered read port;
// dump also waits on the output, and sort runs the compare loop of the selection.
// reset is synchronous and empties the table; the ram itself is not cleared.
// req_stall is high while a command runs; a stalled rsp beat holds the walk.
`default_nettype none
module keyed_record_table_with_sort
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = KRT_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [31:0] req_key_id,
   input  wire logic [31:0] req_new_id,
   input  wire logic [1:0]  req_category,
   input  wire logic        req_descending,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [4:0]       rsp_position,
   output logic [31:0]      rsp_rec_id,
   output logic [1:0]       rsp_rec_category,
   output logic [5:0]       rsp_count,
   output logic             rsp_last
);

   ctl_type ctl;
   sts_type sts;

   krt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_cmd  (req_cmd),
      .req_stall(req_stall),
      .sts      (sts),
      .ctl      (ctl)
   );

   krt_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_key_id      (req_key_id),
      .req_new_id      (req_new_id),
      .req_category    (req_category),
      .req_descending  (req_descending),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_rec_id      (rsp_rec_id),
      .rsp_rec_category(rsp_rec_category),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import krt_pkg::*;

   localparam int DEPTH      = KRT_DEPTH;
   localparam int RAND_ITEMS = 200;
   localparam int CYCLE_CAP  = 1_000_000;

   typedef struct {
      logic [2:0]  status;
      logic [4:0]  position;
      logic [31:0] rec_id;
      logic [1:0]  rec_category;
      logic [5:0]  count;
      logic        last;
   } rsp_beat_type;

   typedef struct {
      logic [2:0]   cmd;
      logic [31:0]  key_id;
      logic [31:0]  new_id;
      logic [1:0]   category;
      logic         descending;
      bit           typed;
      rsp_beat_type typed_rsp;
   } req_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_cmd;
   logic [31:0] req_key_id;
   logic [31:0] req_new_id;
   logic [1:0]  req_category;
   logic        req_descending;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_position;
   logic [31:0] rsp_rec_id;
   logic [1:0]  rsp_rec_category;
   logic [5:0]  rsp_count;
   logic        rsp_last;

   keyed_record_table_with_sort dut (.*);

   // shadow copy of the table
   logic [31:0] tbl_ids [DEPTH];
   logic [1:0]  tbl_cats [DEPTH];
   int          tbl_count;

   rsp_beat_type pending_rsp [$];
   int           error_count;
   int           beats_seen;
   bit           stim_done;
   longint       cycle_num;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_beat_type mk_beat(logic [2:0] st, int pos, logic [31:0] id,
                                            logic [1:0] cat, bit lst);
      rsp_beat_type b;
      b.status       = st;
      b.position     = pos[4:0];
      b.rec_id       = id;
      b.rec_category = cat;
      b.count        = tbl_count[5:0];
      b.last         = lst;
      return b;
   endfunction

   function automatic int find_key(logic [31:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_ids[i] == id) return i;
      return -1;
   endfunction

   // table behavior: update the shadow and queue the beats one command gives
   task automatic table_apply(req_row_type r);
      int          idx;
      int          best;
      logic [31:0] tid;
      logic [1:0]  tcat;
      idx = find_key(r.key_id);
      case (r.cmd)
         CMD_INSERT: begin
            if (idx >= 0)
               pending_rsp.push_back(mk_beat(RS_DUP, idx, tbl_ids[idx], tbl_cats[idx], 1));
            else if (r.category == 2'd0)
               pending_rsp.push_back(mk_beat(RS_BADCAT, 0, 0, 0, 1));
            else if (tbl_count >= DEPTH)
               pending_rsp.push_back(mk_beat(RS_FULL, 0, 0, 0, 1));
            else begin
               tbl_ids[tbl_count]  = r.key_id;
               tbl_cats[tbl_count] = r.category;
               tbl_count++;
               pending_rsp.push_back(mk_beat(RS_OK, tbl_count - 1, r.key_id, r.category, 1));
            end
         end
         CMD_DELETE, CMD_LOOKUP, CMD_MODIFY: begin
            if (tbl_count == 0)
               pending_rsp.push_back(mk_beat(RS_EMPTY, 0, 0, 0, 1));
            else if (idx < 0)
               pending_rsp.push_back(mk_beat(RS_NOTFOUND, 0, 0, 0, 1));
            else if (r.cmd == CMD_DELETE) begin
               tid  = tbl_ids[idx];
               tcat = tbl_cats[idx];
               for (int j = idx; j + 1 < tbl_count; j++) begin
                  tbl_ids[j]  = tbl_ids[j+1];
                  tbl_cats[j] = tbl_cats[j+1];
               end
               tbl_count--;
               pending_rsp.push_back(mk_beat(RS_OK, idx, tid, tcat, 1));
            end else if (r.cmd == CMD_LOOKUP)
               pending_rsp.push_back(mk_beat(RS_OK, idx, tbl_ids[idx], tbl_cats[idx], 1));
            else if (r.category == 2'd0)
               pending_rsp.push_back(mk_beat(RS_BADCAT, idx, tbl_ids[idx], tbl_cats[idx], 1));
            else begin
               tbl_ids[idx]  = r.new_id;
               tbl_cats[idx] = r.category;
               pending_rsp.push_back(mk_beat(RS_OK, idx, r.new_id, r.category, 1));
            end
         end
         CMD_SORT: begin
            if (tbl_count == 0)
               pending_rsp.push_back(mk_beat(RS_EMPTY, 0, 0, 0, 1));
            else begin
               // selection sort, earliest wins on ties
               for (int i = 0; i < tbl_count; i++) begin
                  best = i;
                  for (int j = i + 1; j < tbl_count; j++)
                     if (r.descending ? ($signed(tbl_ids[best]) < $signed(tbl_ids[j]))
                                      : ($signed(tbl_ids[best]) > $signed(tbl_ids[j])))
                        best = j;
                  if (best != i) begin
                     tid            = tbl_ids[i];
                     tcat           = tbl_cats[i];
                     tbl_ids[i]     = tbl_ids[best];
                     tbl_cats[i]    = tbl_cats[best];
                     tbl_ids[best]  = tid;
                     tbl_cats[best] = tcat;
                  end
               end
               pending_rsp.push_back(mk_beat(RS_OK, 0, 0, 0, 1));
            end
         end
         CMD_CLEAR: begin
            tbl_count = 0;
            pending_rsp.push_back(mk_beat(RS_OK, 0, 0, 0, 1));
         end
         CMD_DUMP: begin
            if (tbl_count == 0)
               pending_rsp.push_back(mk_beat(RS_EMPTY, 0, 0, 0, 1));
            else
               for (int i = 0; i < tbl_count; i++)
                  pending_rsp.push_back(mk_beat(RS_OK, i, tbl_ids[i], tbl_cats[i],
                                                i + 1 == tbl_count));
         end
         default: ;  // unknown command, no beat
      endcase
   endtask

   function automatic req_row_type row(logic [2:0] c, logic [31:0] k, logic [31:0] n,
                                       logic [1:0] cat, logic d);
      req_row_type r;
      r.cmd = c; r.key_id = k; r.new_id = n; r.category = cat; r.descending = d;
      r.typed = 0;
      r.typed_rsp = '{default: '0};
      return r;
   endfunction

   function automatic req_row_type row_exp(req_row_type r, logic [2:0] st, int pos,
                                           logic [31:0] id, logic [1:0] cat, int cnt);
      r.typed = 1;
      r.typed_rsp = '{st, pos[4:0], id, cat, cnt[5:0], 1'b1};
      return r;
   endfunction

   // random ids: mostly a small pool so hits and a full table happen
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r == 1) return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      return 32'(-8 + $signed($urandom_range(0, 39)));
   endfunction

   function automatic req_row_type rand_row(int n);
      int          r;
      int          ins_w;
      req_row_type x;
      x = row(CMD_INSERT, pick_key(), ($urandom_range(0, 1) != 0) ? $urandom : pick_key(),
              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if (x.category == 2'd0 && $urandom_range(0, 2) != 0) x.category = 2'd1;
      ins_w = (n % 70 < 50) ? 80 : 30;
      r = $urandom_range(0, 99);
      if (r < ins_w) x.cmd = CMD_INSERT;
      else begin
         r = $urandom_range(0, 99);
         if (r < 20) x.cmd = CMD_DELETE;
         else if (r < 42) x.cmd = CMD_LOOKUP;
         else if (r < 62) x.cmd = CMD_MODIFY;
         else if (r < 74) x.cmd = CMD_SORT;
         else if (r < 80) x.cmd = CMD_CLEAR;
         else if (r < 94) x.cmd = CMD_DUMP;
         else x.cmd = 3'd7;
      end
      return x;
   endfunction

   // drive one request and hold it until accepted
   task automatic send_req(req_row_type r, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= r.cmd;
      req_key_id     <= r.key_id;
      req_new_id     <= r.new_id;
      req_category   <= r.category;
      req_descending <= r.descending;
      do @(posedge clock); while (req_stall);
      table_apply(r);
      if (r.typed) begin
         void'(pending_rsp.pop_back());
         pending_rsp.push_back(r.typed_rsp);
      end
   endtask

   function automatic int draw_gap(int n);
      return ((n / 20) % 3 == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   // stimulus
   initial begin
      req_row_type dir_rows [$];
      int          n;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_cmd        <= CMD_INSERT;
      req_key_id     <= '0;
      req_new_id     <= '0;
      req_category   <= '0;
      req_descending <= 1'b0;
      tbl_count      = 0;
      error_count    = 0;
      stim_done      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty-table cases first, then extremes of the id range
      dir_rows.push_back(row_exp(row(CMD_DUMP, 0, 0, 0, 0), RS_EMPTY, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_LOOKUP, 5, 0, 1, 0), RS_EMPTY, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_DELETE, 5, 0, 1, 0), RS_EMPTY, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_MODIFY, 5, 7, 2, 0), RS_EMPTY, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_SORT, 0, 0, 0, 1), RS_EMPTY, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_INSERT, 9, 0, 0, 0), RS_BADCAT, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_INSERT, 32'h7fff_ffff, 0, 3, 0),
                                 RS_OK, 0, 32'h7fff_ffff, 3, 1));
      dir_rows.push_back(row_exp(row(CMD_INSERT, 32'h8000_0000, 0, 1, 0),
                                 RS_OK, 1, 32'h8000_0000, 1, 2));
      dir_rows.push_back(row_exp(row(CMD_INSERT, 32'h7fff_ffff, 0, 2, 0),
                                 RS_DUP, 0, 32'h7fff_ffff, 3, 2));
      dir_rows.push_back(row(CMD_INSERT, 0, 0, 2, 0));
      dir_rows.push_back(row(CMD_INSERT, 32'hffff_ffff, 0, 1, 0));
      dir_rows.push_back(row(CMD_LOOKUP, 32'h8000_0000, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_LOOKUP, 1234, 0, 0, 0), RS_NOTFOUND, 0, 0, 0, 4));
      // modify with a bad category leaves the record alone
      dir_rows.push_back(row(CMD_MODIFY, 32'h8000_0000, 77, 0, 0));
      dir_rows.push_back(row(CMD_MODIFY, 32'h8000_0000, 32'h7fff_ffff, 2, 0));
      dir_rows.push_back(row(CMD_SORT, 0, 0, 0, 0));
      dir_rows.push_back(row(CMD_DUMP, 0, 0, 0, 0));
      dir_rows.push_back(row(CMD_SORT, 0, 0, 0, 1));
      dir_rows.push_back(row(CMD_DUMP, 0, 0, 0, 0));
      dir_rows.push_back(row(CMD_DELETE, 32'h7fff_ffff, 0, 0, 0));
      dir_rows.push_back(row(3'd7, 32'hffff_ffff, 32'hffff_ffff, 3, 1));
      dir_rows.push_back(row(CMD_DUMP, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_CLEAR, 0, 0, 0, 0), RS_OK, 0, 0, 0, 0));
      dir_rows.push_back(row_exp(row(CMD_DUMP, 0, 0, 0, 0), RS_EMPTY, 0, 0, 0, 0));

      n = 0;
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i], draw_gap(n));
         n++;
      end
      for (int k = 0; k < RAND_ITEMS; k++) begin
         send_req(rand_row(k), draw_gap(n));
         n++;
      end
      req_valid <= 1'b0;

      // drain, then allow for a command that gives no beat
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      stim_done = 1;
   end

   // response side: random stall per beat, one long hold-off to back up the input
   initial begin
      int           wait_cyc;
      bit           long_done;
      rsp_beat_type exp_b;
      rsp_stall  <= 1'b1;
      beats_seen = 0;
      long_done  = 0;
      @(negedge reset);
      forever begin
         wait_cyc = ((beats_seen / 25) % 3 == 1) ? 0 : $urandom_range(0, 18);
         if (!long_done && beats_seen == 60) begin
            wait_cyc  = 600;
            long_done = 1;
         end
         if (wait_cyc > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cyc) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         beats_seen++;
         if (pending_rsp.size() == 0) begin
            $error("unexpected beat: status %0d id %h", rsp_status, rsp_rec_id);
            error_count++;
         end else begin
            exp_b = pending_rsp.pop_front();
            if (rsp_status !== exp_b.status) begin
               $error("status: expected %0d actual %0d", exp_b.status, rsp_status);
               error_count++;
            end
            if (rsp_position !== exp_b.position) begin
               $error("position: expected %0d actual %0d", exp_b.position, rsp_position);
               error_count++;
            end
            if (rsp_rec_id !== exp_b.rec_id) begin
               $error("rec_id: expected %h actual %h", exp_b.rec_id, rsp_rec_id);
               error_count++;
            end
            if (rsp_rec_category !== exp_b.rec_category) begin
               $error("rec_category: expected %0d actual %0d", exp_b.rec_category,
                      rsp_rec_category);
               error_count++;
            end
            if (rsp_count !== exp_b.count) begin
               $error("count: expected %0d actual %0d", exp_b.count, rsp_count);
               error_count++;
            end
            if (rsp_last !== exp_b.last) begin
               $error("last: expected %0d actual %0d", exp_b.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      cycle_num = 0;
      forever begin
         @(posedge clock);
         cycle_num++;
         if (stim_done) begin
            if (error_count == 0 && pending_rsp.size() == 0)
               $display("end of test: clean");
            else
               $display("end of test: mismatches");
            $finish;
         end else if (cycle_num >= CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
